// File: hw/rtl/ecw_pkg.sv
// Shared definitions for the Euler circuit walker: operation codes, default
// sizes and the command/status bundles between controller and datapath.
// No dependencies.
package ecw_pkg;

  localparam int MAX_EDGES_DEF = 63;
  localparam int VERTEX_LIMIT  = 256;
  localparam int VW            = 8;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_WALK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic take_add;
    logic take_walk;
    logic take_clear;
    logic scan;
    logic push;
    logic pop;
    logic pop_load;
    logic emit_add;
  } ecw_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic out_free;
    logic last;
  } ecw_status_t;

endpackage

// File: hw/rtl/ecw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ecw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ecw_ctrl.sv
// Controller for the Euler circuit walker: sequences add, clear and walk
// transactions. Depends on ecw_pkg.
module ecw_ctrl
  import ecw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  output ecw_cmd_t    cmd,
  input  ecw_status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_POPLD = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (operation)
            OP_ADD: begin
              cmd.take_add = 1'b1;
              state_next   = S_ADD;
            end
            OP_WALK: begin
              cmd.take_walk = 1'b1;
              state_next    = S_SCAN;
            end
            OP_CLEAR: cmd.take_clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_ADD: begin
        if (status.out_free) begin
          cmd.emit_add = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          cmd.push = 1'b1;
        end else if (status.miss) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (status.out_free) begin
          cmd.pop    = 1'b1;
          state_next = status.last ? S_IDLE : S_POPLD;
        end
      end
      S_POPLD: begin
        cmd.pop_load = 1'b1;
        state_next   = S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/ecw_datapath.sv
// Datapath for the Euler circuit walker: edge table, used bits, vertex stack,
// edge scan pipeline and result register. Depends on ecw_pkg and ecw_ram.
module ecw_datapath
  import ecw_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  ecw_cmd_t      cmd,
  output ecw_status_t   status,
  input  logic [VW-1:0] vertex_a,
  input  logic [VW-1:0] vertex_b,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] path_vertex,
  output logic          last_vertex,
  output logic          edges_dropped
);

  localparam int CW = $clog2(MAX_EDGES + 1);               // edge count
  localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;  // table index
  localparam int DW = $clog2(MAX_EDGES + 2);               // stack depth incl. top

  logic [CW-1:0]        edge_count;
  logic                 overflow_seen;
  logic                 add_drop;

  logic [VW-1:0]        top;
  logic [DW-1:0]        depth;

  logic [CW-1:0]        issue_cnt;
  logic                 chk_valid;
  logic [IW-1:0]        chk_idx;

  logic [2*VW-1:0]      edge_rdata;
  logic                 used_rdata;
  logic [IW-1:0]        used_waddr;
  logic [VW-1:0]        stack_rdata;
  logic [VW-1:0]        end_one;
  logic [VW-1:0]        end_two;
  logic [VW-1:0]        far_end;

  logic                 in_range;
  logic                 full;
  logic                 add_ok;
  logic                 raw_hit;
  logic                 room;
  logic                 issue;
  logic                 scan_start;
  logic [CW-1:0]        issue_addr;
  logic [DW-1:0]        push_addr;
  logic [DW-1:0]        pop_addr;

  assign in_range = ({24'd0, vertex_a} < 32'(VERTEX_LIMIT)) &&
                    ({24'd0, vertex_b} < 32'(VERTEX_LIMIT));
  assign full     = (edge_count == CW'(MAX_EDGES));
  assign add_ok   = cmd.take_add && in_range && !full;

  assign end_one  = edge_rdata[VW-1:0];
  assign end_two  = edge_rdata[2*VW-1:VW];
  assign far_end  = (end_one == top) ? end_two : end_one;

  assign raw_hit  = chk_valid && !used_rdata && (end_one == top || end_two == top);
  assign room     = (depth != DW'(MAX_EDGES + 1));
  assign issue    = cmd.scan && !raw_hit && (issue_cnt != '0);
  assign issue_addr = issue_cnt - CW'(1);
  assign scan_start = cmd.take_walk || cmd.push || cmd.pop_load;

  assign push_addr = depth - DW'(1);
  assign pop_addr  = depth - DW'(2);

  assign used_waddr = cmd.push ? chk_idx : edge_count[IW-1:0];

  assign status.hit      = raw_hit && room;
  assign status.miss     = (issue_cnt == '0 && !chk_valid) || (raw_hit && !room);
  assign status.out_free = !out_valid || out_ready;
  assign status.last     = (depth == DW'(1));

  ecw_ram #(
    .WIDTH (2 * VW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (add_ok),
    .waddr (edge_count[IW-1:0]),
    .wdata ({vertex_b, vertex_a}),
    .re    (issue),
    .raddr (issue_addr[IW-1:0]),
    .rdata (edge_rdata)
  );

  // Used flags: cleared as each edge is added, set when a walk takes the edge.
  // Read alongside the edge table, so only slots below edge_count are looked at.
  ecw_ram #(
    .WIDTH (1),
    .DEPTH (MAX_EDGES)
  ) u_used_ram (
    .clk   (clk),
    .we    (add_ok || cmd.push),
    .waddr (used_waddr),
    .wdata (cmd.push),
    .re    (issue),
    .raddr (issue_addr[IW-1:0]),
    .rdata (used_rdata)
  );

  // Entries below the top of stack; the top itself lives in a register.
  ecw_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_EDGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (push_addr[IW-1:0]),
    .wdata (top),
    .re    (cmd.pop && !status.last),
    .raddr (pop_addr[IW-1:0]),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.take_clear) begin
      edge_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (add_ok) begin
        edge_count <= edge_count + CW'(1);
      end
      if (cmd.take_add && in_range && full) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_add) begin
      add_drop <= in_range && full;
    end
  end

  // Stack top and depth
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      if (cmd.take_walk) begin
        depth <= DW'(1);
      end else if (cmd.push) begin
        depth <= depth + DW'(1);
      end else if (cmd.pop) begin
        depth <= depth - DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_walk) begin
      top <= vertex_a;
    end else if (cmd.push) begin
      top <= far_end;
    end else if (cmd.pop_load) begin
      top <= stack_rdata;
    end
  end

  // Scan from the newest edge down; one read issued per cycle while no hit is pending, each checked in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      chk_valid <= 1'b0;
    end else if (scan_start) begin
      issue_cnt <= edge_count;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= issue;
      if (issue) begin
        issue_cnt <= issue_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx <= issue_addr[IW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop || cmd.emit_add) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      path_vertex   <= top;
      last_vertex   <= (depth == DW'(1));
      edges_dropped <= overflow_seen;
    end else if (cmd.emit_add) begin
      path_vertex   <= '0;
      last_vertex   <= 1'b0;
      edges_dropped <= add_drop;
    end
  end

endmodule

// File: hw/rtl/euler_circuit_walker.sv
// Euler circuit walker (Hierholzer) over an undirected multigraph of up to
// MAX_EDGES stored edges. An add is accepted and, once the output register is
// free, its result is loaded there; the next input is taken after that. A
// clear gives no result. A walk that takes k of the E stored edges runs 2k+1
// edge scans (one edge-table read per cycle until an edge is found, newest
// edge first): k that find an edge and k+1 that find none. The block takes one
// transaction at a time; a result waiting in the output register does not stop
// a new input being accepted. Depends on ecw_pkg, ecw_ctrl, ecw_datapath and
// ecw_ram.
module euler_circuit_walker
  import ecw_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] vertex_a, [15:8] vertex_b
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] path_vertex
  output logic        m_tlast,   // last_vertex
  output logic [0:0]  m_tuser    // [0] edges_dropped
);

  ecw_cmd_t    cmd;
  ecw_status_t status;

  ecw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .operation (s_tuser),
    .cmd       (cmd),
    .status    (status)
  );

  ecw_datapath #(
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .vertex_a      (s_tdata[7:0]),
    .vertex_b      (s_tdata[15:8]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .path_vertex   (m_tdata),
    .last_vertex   (m_tlast),
    .edges_dropped (m_tuser[0])
  );

endmodule
